// ===== sv/buddy_allocator_top_defines.svh =====
// Assertion macros used by the buddy allocator checker.
`ifndef BUDDY_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BALLOC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BALLOC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

// ===== sv/balloc_pkg.sv =====
package balloc_pkg;

    // Fixed field widths of the stream and configuration ports and of the internal datapath.
    localparam int HEAP_W = 20;
    localparam int SIZE_W = 12;
    localparam int MLOG_W = 2;
    localparam int WIDE_W = 21;
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    localparam logic [HEAP_W-1:0] HEAP_RESET = 20'd262144;
    localparam logic [MLOG_W-1:0] MLOG_RESET = 2'd2;
    localparam logic [MLOG_W-1:0] MLOG_MAX   = 2'd2;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TOO_BIG   = 2'd1,
        STAT_NO_MEM    = 2'd2,
        STAT_NOT_ALLOC = 2'd3
    } status_t;

    typedef enum logic {
        REG_HEAP_SIZE = 1'b0,
        REG_MIN_BLOCK = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CARVE,
        ST_FIND_LVL,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_PUT_RD,
        ST_PUT_WR,
        ST_ALLOC_WR,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_MERGE,
        ST_MERGE_CHK,
        ST_DONE
    } state_t;

endpackage

// ===== sv/buddy_allocator_top.sv =====
// Buddy allocator with LEVELS block levels over a heap of up to MAX_HEAP units (a power of
// two), positions numbered from 1. The free bitmap of all levels lives in one memory of
// 64-bit words, the allocated level of each offset in a second memory; both have registered
// reads and the bitmap is updated by read-modify-write, one access at a time. After reset
// and on every init command a clearing pass sweeps both memories and no item is accepted
// meanwhile; init then carves the heap, with a read and a write of the bitmap per block.
// An allocate scans the bitmap word by word in each level searched, then updates it once
// plus once per split and records the level. A free reads and clears its recorded level,
// merges with each free buddy going up and marks the result free. Items are handled one at
// a time; the result waits in an output register so the next item can be accepted meanwhile.
module buddy_allocator_top #(
    parameter int LEVELS   = 10,
    parameter int MAX_HEAP = 524288
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // request_size [19:0], free_start [39:20]
    input  logic [1:0]  s_axis_tuser,   // cmd [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // start_pos [19:0], block_size [31:20]
    output logic [1:0]  m_axis_tuser,   // status [1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int HEAP_W = balloc_pkg::HEAP_W;
    localparam int SIZE_W = balloc_pkg::SIZE_W;
    localparam int WIDE_W = balloc_pkg::WIDE_W;
    localparam int BIT_W  = balloc_pkg::BIT_W;
    localparam int WORD_W = balloc_pkg::WORD_W;
    localparam int OFF_W  = $clog2(MAX_HEAP);
    localparam int IW     = OFF_W + 1;
    localparam int MW     = IW - BIT_W;
    localparam int MAP_WORDS = 2 * MAX_HEAP / WORD_W;
    localparam int LW     = $clog2(LEVELS);
    localparam int AW     = $clog2(LEVELS + 1);
    localparam int SH_W   = $clog2(LEVELS + 3);
    localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

    // Size of a block of level l.
    function automatic logic [WIDE_W-1:0] blk(logic [1:0] m, logic [LW-1:0] l);
        blk = WIDE_W'(1) << (SH_W'(m) + SH_W'(l));
    endfunction

    // First bitmap index of level l.
    function automatic logic [IW-1:0] lvl_base(logic [1:0] m, logic [LW-1:0] l);
        logic [IW:0] two_c0;
        two_c0   = (IW+1)'(2 * MAX_HEAP) >> m;
        lvl_base = IW'(two_c0 - (two_c0 >> l));
    endfunction

    // Number of bitmap entries of level l.
    function automatic logic [IW-1:0] lvl_count(logic [1:0] m, logic [LW-1:0] l);
        logic [IW:0] c;
        c         = ((IW+1)'(MAX_HEAP) >> m) >> l;
        lvl_count = IW'(c);
    endfunction

    function automatic logic [IW-1:0] map_idx(logic [1:0] m, logic [LW-1:0] l,
                                              logic [OFF_W-1:0] off);
        map_idx = lvl_base(m, l) + IW'(off >> (SH_W'(m) + SH_W'(l)));
    endfunction

    balloc_pkg::state_t state_reg, state_next;
    balloc_pkg::cmd_t   cmd_reg, cmd_next;
    logic [HEAP_W-1:0]  req_reg, req_next;
    logic [HEAP_W-1:0]  fs_reg, fs_next;
    logic [HEAP_W-1:0]  heap_cfg_reg;
    logic [1:0]         mlog_cfg_reg;
    logic [WIDE_W-1:0]  live_heap_reg, live_heap_next;
    logic [1:0]         live_mlog_reg, live_mlog_next;
    logic [OFF_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [LW-1:0]      cur_lvl_reg, cur_lvl_next;
    logic [LW-1:0]      r_reg, r_next;
    logic [OFF_W-1:0]   cur_off_reg, cur_off_next;
    logic [OFF_W-1:0]   base_off_reg, base_off_next;
    logic               put_val_reg, put_val_next;
    logic [WIDE_W-1:0]  pos_reg, pos_next;
    logic [MW-1:0]      wa_reg, wa_next;
    logic [MW-1:0]      last_wa_reg, last_wa_next;
    balloc_pkg::status_t res_stat_reg, res_stat_next;
    logic [HEAP_W-1:0]  res_pos_reg, res_pos_next;
    logic [SIZE_W-1:0]  res_size_reg, res_size_next;
    logic               out_valid_reg, out_valid_next;
    balloc_pkg::status_t out_stat_reg, out_stat_next;
    logic [HEAP_W-1:0]  out_pos_reg, out_pos_next;
    logic [SIZE_W-1:0]  out_size_reg, out_size_next;

    // Memories and their ports.
    logic [WORD_W-1:0]  map_mem [MAP_WORDS];
    logic [WORD_W-1:0]  map_rdata_reg;
    logic [MW-1:0]      map_raddr, map_waddr;
    logic [WORD_W-1:0]  map_wdata;
    logic               map_we;
    logic [AW-1:0]      lvl_mem [MAX_HEAP];
    logic [AW-1:0]      lvl_rdata_reg;
    logic [OFF_W-1:0]   lvl_waddr;
    logic [AW-1:0]      lvl_wdata;
    logic               lvl_we;

    // Shared address path and search helpers.
    logic               probe_buddy;
    logic [OFF_W-1:0]   cur_sz;
    logic [OFF_W-1:0]   probe_off;
    logic [IW-1:0]      cur_idx;
    logic [BIT_W-1:0]   cur_bit;
    logic [IW-1:0]      cur_base, cur_count, cur_last;
    logic [BIT_W-1:0]   lo_bit, hi_bit;
    logic [WORD_W-1:0]  scan_mask, masked;
    logic [BIT_W-1:0]   pe;
    logic [IW-1:0]      found_i;
    logic [OFF_W-1:0]   found_off;
    logic [LW-1:0]      r_calc;
    logic               too_big;
    logic [WIDE_W-1:0]  blk_cur;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == balloc_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_size_reg, out_pos_reg};
    assign m_axis_tuser  = out_stat_reg;

    // Bitmap address of the current level and offset, or of its buddy while merging.
    always_comb
    begin
        blk_cur     = blk(live_mlog_reg, cur_lvl_reg);
        probe_buddy = (state_reg == balloc_pkg::ST_MERGE) ||
                      (state_reg == balloc_pkg::ST_MERGE_CHK);
        cur_sz      = OFF_W'(blk_cur);
        probe_off   = probe_buddy ? (cur_off_reg ^ cur_sz) : cur_off_reg;
        cur_idx     = map_idx(live_mlog_reg, cur_lvl_reg, probe_off);
        cur_bit     = cur_idx[BIT_W-1:0];
    end

    // Lowest free entry of the current level in the word just read.
    always_comb
    begin
        cur_base  = lvl_base(live_mlog_reg, cur_lvl_reg);
        cur_count = lvl_count(live_mlog_reg, cur_lvl_reg);
        cur_last  = cur_base + cur_count - 1'b1;
        lo_bit    = (wa_reg == cur_base[IW-1:BIT_W]) ? cur_base[BIT_W-1:0] : '0;
        hi_bit    = (wa_reg == last_wa_reg) ? cur_last[BIT_W-1:0] : '1;
        scan_mask = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));
        masked    = map_rdata_reg & scan_mask;
        pe        = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (masked[b])
            begin
                pe = BIT_W'(b);
            end
        end
        found_i   = {wa_reg, pe};
        found_off = OFF_W'((found_i - cur_base) << (SH_W'(live_mlog_reg) + SH_W'(cur_lvl_reg)));
    end

    // Smallest level whose block holds the request.
    always_comb
    begin
        too_big = {1'b0, req_reg} > blk(live_mlog_reg, LVL_TOP);
        r_calc  = LVL_TOP;
        for (int l = LEVELS - 2; l >= 0; l--)
        begin
            if (blk(live_mlog_reg, LW'(l)) >= {1'b0, req_reg})
            begin
                r_calc = LW'(l);
            end
        end
    end

    // Next state and memory controls.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        req_next       = req_reg;
        fs_next        = fs_reg;
        live_heap_next = live_heap_reg;
        live_mlog_next = live_mlog_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_lvl_next   = cur_lvl_reg;
        r_next         = r_reg;
        cur_off_next   = cur_off_reg;
        base_off_next  = base_off_reg;
        put_val_next   = put_val_reg;
        pos_next       = pos_reg;
        wa_next        = wa_reg;
        last_wa_next   = last_wa_reg;
        res_stat_next  = res_stat_reg;
        res_pos_next   = res_pos_reg;
        res_size_next  = res_size_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_stat_next  = out_stat_reg;
        out_pos_next   = out_pos_reg;
        out_size_next  = out_size_reg;

        map_raddr = (state_reg == balloc_pkg::ST_FIND_RD) ? wa_reg : cur_idx[IW-1:BIT_W];
        map_waddr = cur_idx[IW-1:BIT_W];
        map_wdata = map_rdata_reg;
        map_we    = 1'b0;
        lvl_waddr = cur_off_reg;
        lvl_wdata = '0;
        lvl_we    = 1'b0;

        unique case (state_reg)
            balloc_pkg::ST_CLEAR:
            begin
                map_waddr = clr_cnt_reg[MW-1:0];
                map_wdata = '0;
                map_we    = (clr_cnt_reg[OFF_W-1:MW] == '0);
                lvl_waddr = clr_cnt_reg;
                lvl_we    = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    if (cmd_reg == balloc_pkg::CMD_INIT)
                    begin
                        pos_next     = WIDE_W'(1);
                        cur_lvl_next = LVL_TOP;
                        state_next   = balloc_pkg::ST_CARVE;
                    end
                    else
                    begin
                        state_next = balloc_pkg::ST_IDLE;
                    end
                end
            end
            balloc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = balloc_pkg::cmd_t'(s_axis_tuser);
                    req_next   = s_axis_tdata[19:0];
                    fs_next    = s_axis_tdata[39:20];
                    state_next = balloc_pkg::ST_DECODE;
                end
            end
            balloc_pkg::ST_DECODE:
            begin
                res_stat_next = balloc_pkg::STAT_OK;
                res_pos_next  = '0;
                res_size_next = '0;
                unique case (cmd_reg)
                    balloc_pkg::CMD_INIT:
                    begin
                        live_heap_next = ({1'b0, heap_cfg_reg} > WIDE_W'(MAX_HEAP)) ?
                                         WIDE_W'(MAX_HEAP) : {1'b0, heap_cfg_reg};
                        live_mlog_next = (mlog_cfg_reg > balloc_pkg::MLOG_MAX) ?
                                         balloc_pkg::MLOG_MAX : mlog_cfg_reg;
                        clr_cnt_next   = '0;
                        state_next     = balloc_pkg::ST_CLEAR;
                    end
                    balloc_pkg::CMD_ALLOC:
                    begin
                        if (too_big)
                        begin
                            res_stat_next = balloc_pkg::STAT_TOO_BIG;
                            state_next    = balloc_pkg::ST_DONE;
                        end
                        else
                        begin
                            r_next       = r_calc;
                            cur_lvl_next = r_calc;
                            state_next   = balloc_pkg::ST_FIND_LVL;
                        end
                    end
                    balloc_pkg::CMD_FREE:
                    begin
                        if (fs_reg == '0 || {1'b0, fs_reg} > WIDE_W'(MAX_HEAP))
                        begin
                            res_stat_next = balloc_pkg::STAT_NOT_ALLOC;
                            state_next    = balloc_pkg::ST_DONE;
                        end
                        else
                        begin
                            cur_off_next = OFF_W'(fs_reg - 1'b1);
                            state_next   = balloc_pkg::ST_FREE_RD;
                        end
                    end
                    default:
                    begin
                        state_next = balloc_pkg::ST_DONE;
                    end
                endcase
            end
            balloc_pkg::ST_CARVE:
            begin
                // Place the largest block that still fits, else step one level down; stop once no smallest block fits.
                if (pos_reg + blk(live_mlog_reg, '0) > live_heap_reg)
                begin
                    state_next = balloc_pkg::ST_DONE;
                end
                else if (pos_reg + blk_cur <= live_heap_reg)
                begin
                    cur_off_next = OFF_W'(pos_reg - 1'b1);
                    pos_next     = pos_reg + blk_cur;
                    put_val_next = 1'b1;
                    state_next   = balloc_pkg::ST_PUT_RD;
                end
                else
                begin
                    cur_lvl_next = cur_lvl_reg - 1'b1;
                end
            end
            balloc_pkg::ST_FIND_LVL:
            begin
                if (cur_count == '0)
                begin
                    if (cur_lvl_reg == LVL_TOP)
                    begin
                        res_stat_next = balloc_pkg::STAT_NO_MEM;
                        state_next    = balloc_pkg::ST_DONE;
                    end
                    else
                    begin
                        cur_lvl_next = cur_lvl_reg + 1'b1;
                    end
                end
                else
                begin
                    wa_next      = cur_base[IW-1:BIT_W];
                    last_wa_next = cur_last[IW-1:BIT_W];
                    state_next   = balloc_pkg::ST_FIND_RD;
                end
            end
            balloc_pkg::ST_FIND_RD:
            begin
                state_next = balloc_pkg::ST_FIND_CHK;
            end
            balloc_pkg::ST_FIND_CHK:
            begin
                if (|masked)
                begin
                    base_off_next = found_off;
                    cur_off_next  = found_off;
                    put_val_next  = 1'b0;
                    state_next    = balloc_pkg::ST_PUT_RD;
                end
                else if (wa_reg == last_wa_reg)
                begin
                    if (cur_lvl_reg == LVL_TOP)
                    begin
                        res_stat_next = balloc_pkg::STAT_NO_MEM;
                        state_next    = balloc_pkg::ST_DONE;
                    end
                    else
                    begin
                        cur_lvl_next = cur_lvl_reg + 1'b1;
                        state_next   = balloc_pkg::ST_FIND_LVL;
                    end
                end
                else
                begin
                    wa_next    = wa_reg + 1'b1;
                    state_next = balloc_pkg::ST_FIND_RD;
                end
            end
            balloc_pkg::ST_PUT_RD:
            begin
                state_next = balloc_pkg::ST_PUT_WR;
            end
            balloc_pkg::ST_PUT_WR:
            begin
                map_wdata          = map_rdata_reg;
                map_wdata[cur_bit] = put_val_reg;
                map_we             = 1'b1;
                unique case (cmd_reg)
                    balloc_pkg::CMD_INIT:
                    begin
                        state_next = balloc_pkg::ST_CARVE;
                    end
                    balloc_pkg::CMD_ALLOC:
                    begin
                        // Free the upper half at each level on the way down.
                        if (cur_lvl_reg > r_reg)
                        begin
                            cur_lvl_next = cur_lvl_reg - 1'b1;
                            cur_off_next = base_off_reg +
                                OFF_W'(blk(live_mlog_reg, cur_lvl_reg - 1'b1));
                            put_val_next = 1'b1;
                            state_next   = balloc_pkg::ST_PUT_RD;
                        end
                        else
                        begin
                            state_next = balloc_pkg::ST_ALLOC_WR;
                        end
                    end
                    default:
                    begin
                        state_next = balloc_pkg::ST_DONE;
                    end
                endcase
            end
            balloc_pkg::ST_ALLOC_WR:
            begin
                lvl_waddr     = base_off_reg;
                lvl_wdata     = AW'(r_reg) + 1'b1;
                lvl_we        = 1'b1;
                res_pos_next  = HEAP_W'(base_off_reg) + 1'b1;
                res_size_next = SIZE_W'(blk(live_mlog_reg, r_reg));
                state_next    = balloc_pkg::ST_DONE;
            end
            balloc_pkg::ST_FREE_RD:
            begin
                state_next = balloc_pkg::ST_FREE_CHK;
            end
            balloc_pkg::ST_FREE_CHK:
            begin
                if (lvl_rdata_reg == '0)
                begin
                    res_stat_next = balloc_pkg::STAT_NOT_ALLOC;
                    state_next    = balloc_pkg::ST_DONE;
                end
                else
                begin
                    lvl_we        = 1'b1;
                    cur_lvl_next  = LW'(lvl_rdata_reg - 1'b1);
                    res_pos_next  = fs_reg;
                    res_size_next = SIZE_W'(blk(live_mlog_reg, LW'(lvl_rdata_reg - 1'b1)));
                    state_next    = balloc_pkg::ST_MERGE;
                end
            end
            balloc_pkg::ST_MERGE:
            begin
                // The buddy's word is read here while below the top level.
                if (cur_lvl_reg < LVL_TOP)
                begin
                    state_next = balloc_pkg::ST_MERGE_CHK;
                end
                else
                begin
                    put_val_next = 1'b1;
                    state_next   = balloc_pkg::ST_PUT_RD;
                end
            end
            balloc_pkg::ST_MERGE_CHK:
            begin
                if (map_rdata_reg[cur_bit])
                begin
                    map_wdata          = map_rdata_reg;
                    map_wdata[cur_bit] = 1'b0;
                    map_we             = 1'b1;
                    cur_off_next       = cur_off_reg & ~cur_sz;
                    cur_lvl_next       = cur_lvl_reg + 1'b1;
                    state_next         = balloc_pkg::ST_MERGE;
                end
                else
                begin
                    put_val_next = 1'b1;
                    state_next   = balloc_pkg::ST_PUT_RD;
                end
            end
            balloc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_pos_next   = res_pos_reg;
                    out_size_next  = res_size_reg;
                    state_next     = balloc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = balloc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= balloc_pkg::ST_CLEAR;
            cmd_reg       <= balloc_pkg::CMD_NOP;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            heap_cfg_reg  <= balloc_pkg::HEAP_RESET;
            mlog_cfg_reg  <= balloc_pkg::MLOG_RESET;
            live_heap_reg <= {1'b0, balloc_pkg::HEAP_RESET};
            live_mlog_reg <= balloc_pkg::MLOG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            live_heap_reg <= live_heap_next;
            live_mlog_reg <= live_mlog_next;
            if (cfg_valid)
            begin
                unique case (balloc_pkg::reg_idx_t'(cfg_index))
                    balloc_pkg::REG_HEAP_SIZE: heap_cfg_reg <= cfg_data;
                    balloc_pkg::REG_MIN_BLOCK: mlog_cfg_reg <= cfg_data[1:0];
                    default:                   heap_cfg_reg <= heap_cfg_reg;
                endcase
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        fs_reg       <= fs_next;
        cur_lvl_reg  <= cur_lvl_next;
        r_reg        <= r_next;
        cur_off_reg  <= cur_off_next;
        base_off_reg <= base_off_next;
        put_val_reg  <= put_val_next;
        pos_reg      <= pos_next;
        wa_reg       <= wa_next;
        last_wa_reg  <= last_wa_next;
        res_stat_reg <= res_stat_next;
        res_pos_reg  <= res_pos_next;
        res_size_reg <= res_size_next;
        out_stat_reg <= out_stat_next;
        out_pos_reg  <= out_pos_next;
        out_size_reg <= out_size_next;
    end

    // Free bitmap memory.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    // Allocated level memory.
    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        lvl_rdata_reg <= lvl_mem[cur_off_reg];
    end

endmodule

// ===== sv/balloc_chk.sv =====
`include "buddy_allocator_top_defines.svh"

module balloc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A failed request reports neither a position nor a size.
    `BALLOC_ASSERT_IMP(fail_zero_payload, m_axis_tvalid && m_axis_tuser != balloc_pkg::STAT_OK, m_axis_tdata == 32'd0)

    // Items are handled one at a time: no item is taken right after another.
    `BALLOC_ASSERT_NXT(one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A result that is not taken stays put.
    `BALLOC_ASSERT_NXT(result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind buddy_allocator_top balloc_chk u_balloc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
